// ===== rtl/wlte_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlte_pkg
// Shared types, widths and the vertex pattern table of the wide line expander.
// ----------------------------------------------------------------------------
package wlte_pkg;

   localparam int SUM_W     = 50;   // dx*dx + dy*dy
   localparam int LEN_W     = 25;   // integer square root of the sum
   localparam int NUM_W     = 40;   // |d| * half width
   localparam int REM_W     = 41;
   localparam int QUO_W     = 16;
   localparam int SQ_STEPS  = 25;
   localparam int DIV_STEPS = 16;
   localparam int LAST_THIN = 5;
   localparam int LAST_FULL = 17;
   localparam int BODY_VTX  = 6;

   localparam logic [1:0] REG_RED   = 2'd0;
   localparam logic [1:0] REG_GREEN = 2'd1;
   localparam logic [1:0] REG_BLUE  = 2'd2;
   localparam logic [1:0] REG_ALPHA = 2'd3;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } color_type;

   typedef struct packed {
      logic               skip;
      logic               full;
      logic signed [23:0] x0;
      logic signed [23:0] y0;
      logic signed [23:0] x1;
      logic signed [23:0] y1;
      logic               sdx;
      logic               sdy;
      logic [9:0]         d;
      logic [8:0]         cov;
   } meta_type;

   typedef struct packed {
      logic             valid;
      logic [SUM_W-1:0] rem;
      logic [SUM_W-1:0] root;
      logic [NUM_W-1:0] nx;
      logic [NUM_W-1:0] ny;
      meta_type         meta;
   } sq_type;

   typedef struct packed {
      logic             valid;
      logic [LEN_W-1:0] len;
      logic [REM_W-1:0] rx;
      logic [REM_W-1:0] ry;
      logic [QUO_W-1:0] qx;
      logic [QUO_W-1:0] qy;
      meta_type         meta;
   } dv_type;

   typedef struct packed {
      logic              end_sel;
      logic signed [1:0] p;
      logic signed [1:0] q;
      logic              u;
      logic              neg;
   } pat_type;

   // x = E.x + p*oy + q*ox ; y = E.y - p*ox + q*oy
   function automatic pat_type pat_lut(input logic [4:0] k);
      pat_type r;
      unique case (k)
         5'd0:  r = '{1'b0,  2'sd1,  2'sd0, 1'b0, 1'b1};
         5'd1:  r = '{1'b0, -2'sd1,  2'sd0, 1'b0, 1'b0};
         5'd2:  r = '{1'b1, -2'sd1,  2'sd0, 1'b0, 1'b0};
         5'd3:  r = '{1'b0,  2'sd1,  2'sd0, 1'b0, 1'b1};
         5'd4:  r = '{1'b1, -2'sd1,  2'sd0, 1'b0, 1'b0};
         5'd5:  r = '{1'b1,  2'sd1,  2'sd0, 1'b0, 1'b1};
         5'd6:  r = '{1'b0,  2'sd1,  2'sd0, 1'b0, 1'b1};
         5'd7:  r = '{1'b0, -2'sd1,  2'sd0, 1'b0, 1'b0};
         5'd8:  r = '{1'b0, -2'sd1, -2'sd1, 1'b1, 1'b0};
         5'd9:  r = '{1'b0,  2'sd1,  2'sd0, 1'b0, 1'b1};
         5'd10: r = '{1'b0, -2'sd1, -2'sd1, 1'b1, 1'b0};
         5'd11: r = '{1'b0,  2'sd1, -2'sd1, 1'b1, 1'b1};
         5'd12: r = '{1'b1, -2'sd1,  2'sd0, 1'b0, 1'b1};
         5'd13: r = '{1'b1,  2'sd1,  2'sd0, 1'b0, 1'b0};
         5'd14: r = '{1'b1,  2'sd1,  2'sd1, 1'b1, 1'b0};
         5'd15: r = '{1'b1, -2'sd1,  2'sd0, 1'b0, 1'b1};
         5'd16: r = '{1'b1,  2'sd1,  2'sd1, 1'b1, 1'b0};
         5'd17: r = '{1'b1, -2'sd1,  2'sd1, 1'b1, 1'b1};
         default: r = '{1'b0, 2'sd0, 2'sd0, 1'b0, 1'b0};
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/wlte_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlte_ifs
// Request (segment) and response (vertex) channels.
// ----------------------------------------------------------------------------
interface wlte_req_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] start_x;
   logic signed [23:0] start_y;
   logic signed [23:0] end_x;
   logic signed [23:0] end_y;
   logic [15:0]        line_width;

   modport source (output valid, start_x, start_y, end_x, end_y, line_width, input ready);
   modport sink   (input valid, start_x, start_y, end_x, end_y, line_width, output ready);
endinterface

interface wlte_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [25:0] vert_x;
   logic signed [25:0] vert_y;
   logic               tex_u;
   logic signed [10:0] tex_v;
   logic [8:0]         coverage;
   logic [7:0]         out_red;
   logic [7:0]         out_green;
   logic [7:0]         out_blue;
   logic [7:0]         out_alpha;
   logic               last;

   modport source (output valid, vert_x, vert_y, tex_u, tex_v, coverage, out_red,
                   out_green, out_blue, out_alpha, last, input ready);
   modport sink   (input valid, vert_x, vert_y, tex_u, tex_v, coverage, out_red,
                   out_green, out_blue, out_alpha, last, output ready);
endinterface

// ===== rtl/wide_line_triangle_expander_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wide_line_triangle_expander_top
// Segment to wide line triangle vertices with square caps.
// ----------------------------------------------------------------------------
// Pipeline: 3 front stages, 25 square root cells and 16 divider cells lead to
// the emitter, which gives one vertex per cycle while rsp.ready is high.
// Throughput: a request enters every cycle while the emitter keeps up; sustained
// one segment per 6 (thin) or 18 vertices, set by the single output port.
// Reset: synchronous; clears pipeline valid bits, emitter and colors (alpha 255).
module wide_line_triangle_expander_top
   import wlte_pkg::*;
#(
   parameter int FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   wlte_req_if.sink    req,
   wlte_rsp_if.source  rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int SH_R = (FRAC_BITS >= 8) ? FRAC_BITS - 8 : 0;
   localparam int SH_L = (FRAC_BITS >= 8) ? 0 : 8 - FRAC_BITS;
   localparam logic [16:0] TH1 = 17'(1 << FRAC_BITS);
   localparam logic [16:0] TH2 = 17'(2 << FRAC_BITS);
   localparam logic [16:0] TH3 = 17'(3 << FRAC_BITS);
   localparam logic [14:0] H_ONE  = 15'(1 << FRAC_BITS);
   localparam logic [14:0] H_HALF = 15'((3 << FRAC_BITS) >> 1);

   typedef struct packed {
      logic               valid;
      logic signed [24:0] dx;
      logic signed [24:0] dy;
      logic [14:0]        h;
      meta_type           meta;
   } s0_type;

   typedef struct packed {
      logic             valid;
      logic [SUM_W-1:0] dx2;
      logic [SUM_W-1:0] dy2;
      logic [NUM_W-1:0] nx;
      logic [NUM_W-1:0] ny;
      meta_type         meta;
   } s1_type;

   color_type color_ff;
   s0_type    s0_ff, s0_in;
   s1_type    s1_ff, s1_in;
   sq_type    sq_chain [0:SQ_STEPS];
   dv_type    dv_chain [0:DIV_STEPS];
   logic      en, take;
   logic [19:0] th8;
   logic [9:0]  half;
   logic [16:0] th;
   logic [24:0] adx, ady;
   logic [LEN_W-1:0] root_len;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= '{8'd0, 8'd0, 8'd0, 8'd255};
      end else if (psel && penable && pwrite) begin
         unique case (paddr[3:2])
            REG_RED:   color_ff.red   <= pwdata[7:0];
            REG_GREEN: color_ff.green <= pwdata[7:0];
            REG_BLUE:  color_ff.blue  <= pwdata[7:0];
            REG_ALPHA: color_ff.alpha <= pwdata[7:0];
            default:   color_ff       <= color_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_RED:   prdata = {24'd0, color_ff.red};
         REG_GREEN: prdata = {24'd0, color_ff.green};
         REG_BLUE:  prdata = {24'd0, color_ff.blue};
         REG_ALPHA: prdata = {24'd0, color_ff.alpha};
         default:   prdata = '0;
      endcase
   end
   assign pready = 1'b1;

   assign en        = !dv_chain[DIV_STEPS].valid || take;
   assign req.ready = en;

   // stage 0: differences and thickness class
   always_comb begin
      th   = {1'b0, req.line_width};
      th8  = (20'(req.line_width) >> SH_R) << SH_L;
      half = 10'(th8 >> 1);
      s0_in.valid   = req.valid;
      s0_in.dx      = 25'(req.end_x) - 25'(req.start_x);
      s0_in.dy      = 25'(req.end_y) - 25'(req.start_y);
      s0_in.meta.x0 = req.start_x;
      s0_in.meta.y0 = req.start_y;
      s0_in.meta.x1 = req.end_x;
      s0_in.meta.y1 = req.end_y;
      s0_in.meta.sdx  = s0_in.dx[24];
      s0_in.meta.sdy  = s0_in.dy[24];
      s0_in.meta.full = (th >= TH1);
      s0_in.meta.skip = (req.line_width == 16'd0) || (s0_in.dx == '0 && s0_in.dy == '0);
      if (th < TH2) begin
         s0_in.h        = H_ONE;
         s0_in.meta.d   = 10'd512 - half;
         s0_in.meta.cov = 9'(half);
      end else if (th < TH3) begin
         s0_in.h        = H_HALF;
         s0_in.meta.d   = 10'd640 - half;
         s0_in.meta.cov = 9'd256;
      end else begin
         s0_in.h        = req.line_width[15:1];
         s0_in.meta.d   = 10'd256;
         s0_in.meta.cov = 9'd256;
      end
   end

   // stage 1: squares and scaled numerators
   always_comb begin
      adx = s0_ff.dx[24] ? 25'(-s0_ff.dx) : 25'(s0_ff.dx);
      ady = s0_ff.dy[24] ? 25'(-s0_ff.dy) : 25'(s0_ff.dy);
      s1_in.valid = s0_ff.valid;
      s1_in.dx2   = SUM_W'(adx) * SUM_W'(adx);
      s1_in.dy2   = SUM_W'(ady) * SUM_W'(ady);
      s1_in.nx    = NUM_W'(adx) * NUM_W'(s0_ff.h);
      s1_in.ny    = NUM_W'(ady) * NUM_W'(s0_ff.h);
      s1_in.meta  = s0_ff.meta;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.valid       <= 1'b0;
         s1_ff.valid       <= 1'b0;
         sq_chain[0].valid <= 1'b0;
      end else if (en) begin
         s0_ff <= s0_in;
         s1_ff <= s1_in;
         sq_chain[0].valid <= s1_ff.valid;
         sq_chain[0].rem   <= s1_ff.dx2 + s1_ff.dy2;
         sq_chain[0].root  <= '0;
         sq_chain[0].nx    <= s1_ff.nx;
         sq_chain[0].ny    <= s1_ff.ny;
         sq_chain[0].meta  <= s1_ff.meta;
      end
   end

   genvar i;
   generate
      for (i = 0; i < SQ_STEPS; i++) begin : g_sqrt
         wlte_sqrt_cell #(.STEP(i)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .en       (en),
            .cell_in  (sq_chain[i]),
            .cell_out (sq_chain[i+1])
         );
      end
   endgenerate

   assign root_len = sq_chain[SQ_STEPS].root[LEN_W-1:0];

   always_comb begin
      dv_chain[0].valid = sq_chain[SQ_STEPS].valid;
      dv_chain[0].len   = (root_len == '0) ? LEN_W'(1) : root_len;
      dv_chain[0].rx    = REM_W'(sq_chain[SQ_STEPS].nx);
      dv_chain[0].ry    = REM_W'(sq_chain[SQ_STEPS].ny);
      dv_chain[0].qx    = '0;
      dv_chain[0].qy    = '0;
      dv_chain[0].meta  = sq_chain[SQ_STEPS].meta;
   end

   generate
      for (i = 0; i < DIV_STEPS; i++) begin : g_div
         wlte_div_cell #(.STEP(i)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .en       (en),
            .cell_in  (dv_chain[i]),
            .cell_out (dv_chain[i+1])
         );
      end
   endgenerate

   wlte_emit u_emit (
      .clock (clock),
      .reset (reset),
      .seg   (dv_chain[DIV_STEPS]),
      .color (color_ff),
      .take  (take),
      .rsp   (rsp)
   );

endmodule

// ===== rtl/wlte_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlte_sqrt_cell
// One restoring square root step; a chain of these resolves the length.
// ----------------------------------------------------------------------------
module wlte_sqrt_cell
   import wlte_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic   clock,
   input  logic   reset,
   input  logic   en,
   input  sq_type cell_in,
   output sq_type cell_out
);

   localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * STEP);

   sq_type           cell_ff, cell_in_nx;
   logic [SUM_W-1:0] trial;

   always_comb begin
      trial      = cell_in.root + BIT;
      cell_in_nx = cell_in;
      if (cell_in.rem >= trial) begin
         cell_in_nx.rem  = cell_in.rem - trial;
         cell_in_nx.root = (cell_in.root >> 1) + BIT;
      end else begin
         cell_in_nx.root = cell_in.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (en) begin
         cell_ff <= cell_in_nx;
      end
   end

   assign cell_out = cell_ff;

endmodule

// ===== rtl/wlte_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlte_div_cell
// One restoring division step for both offset lanes.
// ----------------------------------------------------------------------------
module wlte_div_cell
   import wlte_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic   clock,
   input  logic   reset,
   input  logic   en,
   input  dv_type cell_in,
   output dv_type cell_out
);

   localparam int B = QUO_W - 1 - STEP;

   dv_type           cell_ff, cell_in_nx;
   logic [REM_W-1:0] dsh;

   always_comb begin
      dsh        = REM_W'(cell_in.len) << B;
      cell_in_nx = cell_in;
      if (cell_in.rx >= dsh) begin
         cell_in_nx.rx    = cell_in.rx - dsh;
         cell_in_nx.qx[B] = 1'b1;
      end
      if (cell_in.ry >= dsh) begin
         cell_in_nx.ry    = cell_in.ry - dsh;
         cell_in_nx.qy[B] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (en) begin
         cell_ff <= cell_in_nx;
      end
   end

   assign cell_out = cell_ff;

endmodule

// ===== rtl/wlte_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlte_emit
// Holds one resolved segment, walks its vertex pattern one per cycle on rsp.ready.
// ----------------------------------------------------------------------------
module wlte_emit
   import wlte_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  dv_type            seg,
   input  color_type         color,
   output logic              take,
   wlte_rsp_if.source        rsp
);

   logic               busy_ff, busy_in;
   logic [4:0]         k_ff, k_in;
   logic signed [16:0] ox_ff, oy_ff;
   meta_type           meta_ff;
   logic               fire, at_end;
   pat_type            pat;
   logic signed [25:0] bx, by, tox, toy;

   function automatic logic signed [25:0] term(input logic signed [1:0] c,
                                               input logic signed [16:0] v);
      logic signed [25:0] r;
      case (c)
         2'sd1:   r = 26'(v);
         -2'sd1:  r = -26'(v);
         default: r = '0;
      endcase
      return r;
   endfunction

   assign at_end = (k_ff == (meta_ff.full ? 5'(LAST_FULL) : 5'(LAST_THIN)));
   assign fire   = busy_ff && rsp.ready;
   assign take   = seg.valid && (!busy_ff || (fire && at_end));

   always_comb begin
      busy_in = busy_ff;
      k_in    = k_ff;
      if (fire) begin
         if (at_end) begin
            busy_in = 1'b0;
         end else begin
            k_in = k_ff + 5'd1;
         end
      end
      if (take && !seg.meta.skip) begin
         busy_in = 1'b1;
         k_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         k_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         k_ff    <= k_in;
      end
      if (take && !seg.meta.skip) begin
         meta_ff <= seg.meta;
         ox_ff   <= seg.meta.sdx ? -$signed({1'b0, seg.qx}) : $signed({1'b0, seg.qx});
         oy_ff   <= seg.meta.sdy ? -$signed({1'b0, seg.qy}) : $signed({1'b0, seg.qy});
      end
   end

   always_comb begin
      pat = pat_lut(k_ff);
      bx  = pat.end_sel ? 26'(meta_ff.x1) : 26'(meta_ff.x0);
      by  = pat.end_sel ? 26'(meta_ff.y1) : 26'(meta_ff.y0);
      tox = term(pat.p, oy_ff) + term(pat.q, ox_ff);
      toy = term(pat.q, oy_ff) - term(pat.p, ox_ff);
   end

   assign rsp.valid     = busy_ff;
   assign rsp.vert_x    = bx + tox;
   assign rsp.vert_y    = by + toy;
   assign rsp.tex_u     = pat.u;
   assign rsp.tex_v     = (k_ff < 5'(BODY_VTX))
                          ? (pat.neg ? -$signed({1'b0, meta_ff.d}) : $signed({1'b0, meta_ff.d}))
                          : (pat.neg ? -11'sd256 : 11'sd256);
   assign rsp.coverage  = meta_ff.cov;
   assign rsp.out_red   = color.red;
   assign rsp.out_green = color.green;
   assign rsp.out_blue  = color.blue;
   assign rsp.out_alpha = color.alpha;
   assign rsp.last      = at_end;

   a_k_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (k_ff <= 5'(LAST_FULL)))
      else $error("vertex index out of range");
   a_thin_body: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !meta_ff.full) |-> (k_ff <= 5'(LAST_THIN)))
      else $error("thin line past body vertices");
   a_load: assert property (@(posedge clock) disable iff (reset)
      (take && !seg.meta.skip) |=> (busy_ff && k_ff == 5'd0))
      else $error("segment load did not restart walk");
   a_drop_idle: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && fire && at_end && !seg.valid) |=> !busy_ff)
      else $error("walk did not finish");

endmodule

// ===== tb/wlte_scoreboard.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlte_scoreboard
// Predicts the vertex stream of the wide line expander from accepted segments
// and checks every vertex against the oldest prediction.
// ----------------------------------------------------------------------------
class wlte_scoreboard;

   typedef struct packed {
      logic signed [25:0] vert_x;
      logic signed [25:0] vert_y;
      logic               tex_u;
      logic signed [10:0] tex_v;
      logic [8:0]         coverage;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic [7:0]         alpha;
      logic               last;
   } vertex_type;

   vertex_type   pending_vertices[$];
   logic [7:0]   color[4];
   int           errors;
   int           vertex_count;

   function new();
      color[0] = 8'd0;
      color[1] = 8'd0;
      color[2] = 8'd0;
      color[3] = 8'd255;
      errors = 0;
      vertex_count = 0;
   endfunction

   function void set_color(int idx, logic [7:0] value);
      if (idx < 4)
         color[idx] = value;
   endfunction

   function longint root_floor(longint n);
      longint lo, hi, mid;
      lo = 0;
      hi = 64'd4000000000;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         if (mid * mid <= n)
            lo = mid;
         else
            hi = mid - 1;
      end
      return lo;
   endfunction

   // Expand one accepted segment into its vertices.
   function void note_segment(logic signed [23:0] sx, logic signed [23:0] sy,
                              logic signed [23:0] ex, logic signed [23:0] ey,
                              logic [15:0] lw);
      longint     x0, y0, x1, y1, dx, dy, len, h, d, cov, ox, oy, th8;
      longint     bx, by, vx, vy, tv;
      int         count;
      int         sel, pp, qq, uu, ss;
      vertex_type v;
      // end_sel, p, q, u, s for each vertex
      int shape[18][5] = '{
         '{0, 1, 0, 0, -1}, '{0, -1, 0, 0, 1}, '{1, -1, 0, 0, 1},
         '{0, 1, 0, 0, -1}, '{1, -1, 0, 0, 1}, '{1, 1, 0, 0, -1},
         '{0, 1, 0, 0, -1}, '{0, -1, 0, 0, 1}, '{0, -1, -1, 1, 1},
         '{0, 1, 0, 0, -1}, '{0, -1, -1, 1, 1}, '{0, 1, -1, 1, -1},
         '{1, -1, 0, 0, -1}, '{1, 1, 0, 0, 1}, '{1, 1, 1, 1, 1},
         '{1, -1, 0, 0, -1}, '{1, 1, 1, 1, 1}, '{1, -1, 1, 1, -1}};
      x0 = sx; y0 = sy; x1 = ex; y1 = ey;
      dx = x1 - x0;
      dy = y1 - y0;
      if (lw == 0 || (dx == 0 && dy == 0))
         return;
      len = root_floor(dx * dx + dy * dy);
      if (len < 1)
         len = 1;
      th8 = lw;
      if (lw < 16'd512) begin
         h = 256; d = 512 - th8 / 2; cov = th8 / 2;
      end else if (lw < 16'd768) begin
         h = 384; d = 640 - th8 / 2; cov = 256;
      end else begin
         h = th8 / 2; d = 256; cov = 256;
      end
      // SV signed division truncates toward zero
      ox = (dx * h) / len;
      oy = (dy * h) / len;
      count = (lw < 16'd256) ? 6 : 18;
      for (int k = 0; k < count; k++) begin
         sel = shape[k][0]; pp = shape[k][1]; qq = shape[k][2];
         uu = shape[k][3]; ss = shape[k][4];
         bx = sel ? x1 : x0;
         by = sel ? y1 : y0;
         vx = bx + pp * oy + qq * ox;
         vy = by - pp * ox + qq * oy;
         tv = (k < 6) ? ss * d : ss * 256;
         v.vert_x   = vx[25:0];
         v.vert_y   = vy[25:0];
         v.tex_u    = uu[0];
         v.tex_v    = tv[10:0];
         v.coverage = cov[8:0];
         v.red      = color[0];
         v.green    = color[1];
         v.blue     = color[2];
         v.alpha    = color[3];
         v.last     = (k == count - 1);
         pending_vertices.push_back(v);
      end
   endfunction

   function void check_vertex(vertex_type got);
      vertex_type want;
      vertex_count++;
      if (pending_vertices.size() == 0) begin
         errors++;
         $display("%0t: unexpected vertex %h", $time, got);
         return;
      end
      want = pending_vertices.pop_front();
      if (got.vert_x !== want.vert_x)
         report("vert_x", want.vert_x, got.vert_x);
      if (got.vert_y !== want.vert_y)
         report("vert_y", want.vert_y, got.vert_y);
      if (got.tex_u !== want.tex_u)
         report("tex_u", want.tex_u, got.tex_u);
      if (got.tex_v !== want.tex_v)
         report("tex_v", want.tex_v, got.tex_v);
      if (got.coverage !== want.coverage)
         report("coverage", want.coverage, got.coverage);
      if (got.red !== want.red)
         report("out_red", want.red, got.red);
      if (got.green !== want.green)
         report("out_green", want.green, got.green);
      if (got.blue !== want.blue)
         report("out_blue", want.blue, got.blue);
      if (got.alpha !== want.alpha)
         report("out_alpha", want.alpha, got.alpha);
      if (got.last !== want.last)
         report("last", want.last, got.last);
   endfunction

   function void report(string field, logic [31:0] want, logic [31:0] got);
      errors++;
      $display("%0t: vertex %0d %s expected %h actual %h", $time, vertex_count,
               field, want, got);
   endfunction

endclass

// ===== tb/wide_line_triangle_expander_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wide_line_triangle_expander_top_test
// Drives directed and random segments with random color settings and random
// gaps on both channels; every vertex is checked against a software expansion.
// ----------------------------------------------------------------------------
module wide_line_triangle_expander_top_test
   import wlte_pkg::*;
();

   localparam int DRAIN_CYCLES = 80;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   logic        sink_hold;
   logic        req_done;

   wlte_req_if req_ch();
   wlte_rsp_if rsp_ch();

   wlte_scoreboard vertex_board;

   wide_line_triangle_expander_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch.sink),
      .rsp     (rsp_ch.source),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   task automatic write_color(logic [1:0] idx, logic [7:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {24'($urandom_range(0, 16777215)), value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      vertex_board.set_color(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_all_colors(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                 logic [7:0] a);
      write_color(REG_RED, r);
      write_color(REG_GREEN, g);
      write_color(REG_BLUE, b);
      write_color(REG_ALPHA, a);
   endtask

   // Waits for all vertices, then for the pipeline, since dropped segments
   // may still be in flight.
   task automatic drain();
      while (vertex_board.pending_vertices.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_segment(logic [23:0] sx, logic [23:0] sy, logic [23:0] ex,
                               logic [23:0] ey, logic [15:0] lw, bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 13) : 0;
      if ($urandom_range(0, 3) == 0)
         gap = 0;
      if (gap != 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid      <= 1'b1;
      req_ch.start_x    <= sx;
      req_ch.start_y    <= sy;
      req_ch.end_x      <= ex;
      req_ch.end_y      <= ey;
      req_ch.line_width <= lw;
      do
         @(posedge clock);
      while (!req_ch.ready);
      vertex_board.note_segment(sx, sy, ex, ey, lw);
   endtask

   task automatic end_requests();
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   // Mostly modest coordinates so offsets stay meaningful, some full range.
   function automatic logic [23:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return 24'($urandom());
         1: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
         default: return 24'($signed($urandom_range(0, 65535)) - 32768);
      endcase
   endfunction

   function automatic logic [15:0] pick_width();
      case ($urandom_range(0, 7))
         0: return 16'($urandom_range(0, 255));
         1: return 16'($urandom_range(256, 511));
         2: return 16'($urandom_range(512, 767));
         3: return 16'($urandom());
         4: return 16'd0;
         default: return 16'($urandom_range(768, 4096));
      endcase
   endfunction

   task automatic random_segments(int n);
      logic [23:0] sx, sy, ex, ey;
      for (int i = 0; i < n; i++) begin
         sx = pick_coord();
         sy = pick_coord();
         case ($urandom_range(0, 9))
            0: begin
               ex = sx; ey = sy;
            end
            1: begin
               ex = sx; ey = pick_coord();
            end
            2: begin
               ex = pick_coord(); ey = sy;
            end
            default: begin
               ex = pick_coord(); ey = pick_coord();
            end
         endcase
         send_segment(sx, sy, ex, ey, pick_width(), 1'b1);
      end
      end_requests();
   endtask

   // Result side: a random wait before each vertex, plus one long hold while
   // the sender keeps going.
   initial begin
      int idle;
      rsp_ch.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         idle = $urandom_range(0, 13);
         if ($urandom_range(0, 2) != 0)
            idle = 0;
         @(negedge clock);
         while (idle != 0 || sink_hold) begin
            rsp_ch.ready <= 1'b0;
            if (idle != 0)
               idle--;
            @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do
            @(posedge clock);
         while (!rsp_ch.valid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         vertex_board.check_vertex('{rsp_ch.vert_x, rsp_ch.vert_y, rsp_ch.tex_u,
            rsp_ch.tex_v, rsp_ch.coverage, rsp_ch.out_red, rsp_ch.out_green,
            rsp_ch.out_blue, rsp_ch.out_alpha, rsp_ch.last});
   end

   initial begin
      sink_hold = 1'b0;
      wait (req_done === 1'b0);
      wait (reset === 1'b0);
      // hold once the block has a backlog
      wait (vertex_board != null && vertex_board.pending_vertices.size() > 40);
      sink_hold = 1'b1;
      repeat (300) @(posedge clock);
      sink_hold = 1'b0;
   end

   initial begin
      #50ms;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      vertex_board = new();
      reset        = 1'b1;
      req_done     = 1'b0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      req_ch.valid      = 1'b0;
      req_ch.start_x    = '0;
      req_ch.start_y    = '0;
      req_ch.end_x      = '0;
      req_ch.end_y      = '0;
      req_ch.line_width = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset colors first, then directed cases
      send_segment(24'd0, 24'd0, 24'd2560, 24'd0, 16'd1024, 1'b0);
      send_segment(24'd100, 24'd100, 24'd100, 24'd100, 16'd512, 1'b0);   // zero length
      send_segment(24'd0, 24'd0, 24'd256, 24'd256, 16'd0, 1'b0);          // zero width
      send_segment(24'd0, 24'd0, 24'd0, 24'd768, 16'd128, 1'b0);          // thin
      send_segment(24'd0, 24'd0, 24'd0, 24'd768, 16'd255, 1'b0);
      send_segment(24'd0, 24'd0, -24'sd500, 24'd300, 16'd256, 1'b0);
      send_segment(24'd0, 24'd0, 24'd500, -24'sd300, 16'd511, 1'b0);
      send_segment(24'd10, 24'd20, 24'd900, 24'd77, 16'd512, 1'b0);
      send_segment(24'd10, 24'd20, -24'sd900, -24'sd77, 16'd767, 1'b0);
      send_segment(24'd0, 24'd0, 24'd3000, 24'd4000, 16'd768, 1'b0);
      send_segment(24'd0, 24'd0, 24'd3000, 24'd4000, 16'hFFFF, 1'b0);
      send_segment(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 1'b0);
      send_segment(24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF, 16'd1, 1'b0);
      send_segment(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFE, 24'h7FFFFF, 16'd300, 1'b0);
      send_segment(24'h800000, 24'h000000, 24'h800000, 24'h000001, 16'h8000, 1'b0);
      send_segment(24'hAAAAAA, 24'h555555, 24'h555555, 24'hAAAAAA, 16'hAAAA, 1'b0);
      send_segment(24'h555555, 24'hAAAAAA, 24'hAAAAAA, 24'h555555, 16'h5555, 1'b0);
      end_requests();
      drain();

      set_all_colors(8'hFF, 8'hFF, 8'hFF, 8'h00);
      random_segments(120);
      drain();

      set_all_colors(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()));
      random_segments(190);
      drain();

      set_all_colors(8'h00, 8'h00, 8'h00, 8'hFF);
      write_color(REG_RED, 8'($urandom()));
      random_segments(190);
      drain();

      req_done = 1'b1;
      if (vertex_board.errors == 0 && vertex_board.pending_vertices.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
